// ===== src/mqsb_pkg.sv =====
// Package for the shared-buffer multi-queue block.
// Holds slot, pointer and data sizes, the pointer type and the command codes.
// No dependencies.
`timescale 1ns / 1ps

package mqsb_pkg;

  localparam int QUEUE_ID_W = 3;
  localparam int NUM_QUEUES = 1 << QUEUE_ID_W;
  localparam int NUM_SLOTS  = 64;
  localparam int DATA_WIDTH = 32;

  // slot index, and pointer that also encodes null as NUM_SLOTS
  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int PTR_W = $clog2(NUM_SLOTS + 1);

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [QUEUE_ID_W-1:0] qid_t;

  localparam ptr_t PTR_NULL = ptr_t'(NUM_SLOTS);

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

endpackage

// ===== src/multi_queue_shared_buffer.sv =====
// Top level of the shared-buffer multi-queue block: pointer logic, link and
// data slot stores, and the result pipeline. Depends on mqsb_pkg.
//
// NUM_QUEUES FIFO queues share one store of NUM_SLOTS slots; each queue is a
// linked list of slots, and unused slots sit on a free list. An enqueue item
// (tuser[0] = 0) stores tdata in queue tuser[3:1]; a dequeue item (tuser[0] = 1)
// returns the oldest value of that queue. Every item gives exactly one result:
// tuser = 1 on success, 0 when the store is full (enqueue) or the queue is
// empty (dequeue); tdata holds the dequeued value, else 0. One item is taken
// every cycle while the result side keeps up. An accepted item passes
// through the input register, the registered read port of the data store,
// which forms the result stage, and the output register. The next-slot
// pointer of every list is kept in a register so that back-to-back
// operations on one list need only one registered link read each. The link
// store comes out of reset as a chain through valid bits, so there is no
// clearing pass after reset.
`timescale 1ns / 1ps

module multi_queue_shared_buffer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [mqsb_pkg::DATA_WIDTH-1:0] s_axis_tdata_i,  // value_in
  input  logic [3:0]                    s_axis_tuser_i,  // command, queue_id[2:0]
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [mqsb_pkg::DATA_WIDTH-1:0] m_axis_tdata_o,  // value_out
  output logic                          m_axis_tuser_o   // ok
);

  import mqsb_pkg::*;

  // input stage
  logic  e_valid_q;
  cmd_e  e_cmd_q;
  qid_t  e_qid_q;
  data_t e_val_q;

  // result stage (value comes from the data store read register)
  logic  r_valid_q, r_ok_q, r_deq_q;
  data_t data_rdata_q;

  // output stage
  logic  o_valid_q, o_ok_q;
  data_t o_val_q;

  // queue pointers and free list
  ptr_t head_q  [NUM_QUEUES];
  ptr_t tail_q  [NUM_QUEUES];
  ptr_t hnext_q [NUM_QUEUES];
  ptr_t head_d  [NUM_QUEUES];
  ptr_t tail_d  [NUM_QUEUES];
  ptr_t hnext_d [NUM_QUEUES];
  ptr_t hnext_eff [NUM_QUEUES];
  ptr_t free_head_q, free_head_d;
  ptr_t free_next_q, free_next_d, free_next_eff;

  // link read result pending for one list's next pointer
  logic fwd_valid_q, fwd_valid_d;
  logic fwd_free_q, fwd_free_d;
  logic fwd_nil_q, fwd_nil_d;
  qid_t fwd_qid_q, fwd_qid_d;
  ptr_t fwd_value;

  // stores
  ptr_t            link_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] link_vld_q;
  ptr_t            link_rdata_q;
  data_t           data_mem [NUM_SLOTS];

  logic link_we;
  idx_t link_wa, link_ra;
  ptr_t link_wd;
  logic data_we;

  logic o_ready, r_ready, r_fire, e_fire;
  ptr_t sel_head, sel_tail, sel_hnext;
  logic enq_ok, deq_ok;

  assign o_ready = !o_valid_q || m_axis_tready_i;
  assign r_fire  = r_valid_q && o_ready;
  assign r_ready = !r_valid_q || o_ready;
  assign e_fire  = e_valid_q && r_ready;

  assign s_axis_tready_o = !e_valid_q || r_ready;
  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = o_val_q;
  assign m_axis_tuser_o  = o_ok_q;

  assign fwd_value = fwd_nil_q ? PTR_NULL : link_rdata_q;

  always_comb begin
    for (int i = 0; i < NUM_QUEUES; i++) begin
      hnext_eff[i] = (fwd_valid_q && !fwd_free_q && (fwd_qid_q == qid_t'(i))) ?
                     fwd_value : hnext_q[i];
    end
    free_next_eff = (fwd_valid_q && fwd_free_q) ? fwd_value : free_next_q;
  end

  assign sel_head  = head_q[e_qid_q];
  assign sel_tail  = tail_q[e_qid_q];
  assign sel_hnext = hnext_eff[e_qid_q];
  assign enq_ok    = (e_cmd_q == CMD_ENQ) && (free_head_q != PTR_NULL);
  assign deq_ok    = (e_cmd_q == CMD_DEQ) && (sel_head != PTR_NULL);

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    hnext_d     = hnext_eff;
    free_head_d = free_head_q;
    free_next_d = free_next_eff;
    link_we     = 1'b0;
    link_wa     = '0;
    link_wd     = '0;
    link_ra     = '0;
    data_we     = 1'b0;
    fwd_valid_d = 1'b0;
    fwd_free_d  = 1'b0;
    fwd_nil_d   = 1'b0;
    fwd_qid_d   = '0;
    if (e_fire && enq_ok) begin
      // pop the free list, prefetch the link of its new head
      free_head_d = free_next_eff;
      link_ra     = free_next_eff[IDX_W-1:0];
      fwd_valid_d = 1'b1;
      fwd_free_d  = 1'b1;
      fwd_nil_d   = (free_next_eff == PTR_NULL);
      data_we     = 1'b1;
      if (sel_head == PTR_NULL) begin
        head_d[e_qid_q]  = free_head_q;
        hnext_d[e_qid_q] = PTR_NULL;
      end else begin
        link_we = 1'b1;
        link_wa = sel_tail[IDX_W-1:0];
        link_wd = free_head_q;
        if (sel_head == sel_tail) begin
          hnext_d[e_qid_q] = free_head_q;
        end
      end
      tail_d[e_qid_q] = free_head_q;
    end else if (e_fire && deq_ok) begin
      // advance the head; the link of the tail is stale, so treat it as null
      head_d[e_qid_q] = sel_hnext;
      link_ra         = sel_hnext[IDX_W-1:0];
      fwd_valid_d     = 1'b1;
      fwd_qid_d       = e_qid_q;
      fwd_nil_d       = (sel_hnext == PTR_NULL) || (sel_hnext == sel_tail);
      // push the freed slot onto the free list
      link_we     = 1'b1;
      link_wa     = sel_head[IDX_W-1:0];
      link_wd     = free_head_q;
      free_head_d = sel_head;
      free_next_d = free_head_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      r_valid_q   <= 1'b0;
      o_valid_q   <= 1'b0;
      free_head_q <= '0;
      free_next_q <= ptr_t'(1);
      fwd_valid_q <= 1'b0;
      fwd_free_q  <= 1'b0;
      fwd_nil_q   <= 1'b0;
      fwd_qid_q   <= '0;
      link_vld_q  <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i]  <= PTR_NULL;
        tail_q[i]  <= PTR_NULL;
        hnext_q[i] <= PTR_NULL;
      end
    end else begin
      if (s_axis_tready_o) begin
        e_valid_q <= s_axis_tvalid_i;
      end
      if (r_ready) begin
        r_valid_q <= e_valid_q;
      end
      if (o_ready) begin
        o_valid_q <= r_valid_q;
      end
      free_head_q <= free_head_d;
      free_next_q <= free_next_d;
      fwd_valid_q <= fwd_valid_d;
      fwd_free_q  <= fwd_free_d;
      fwd_nil_q   <= fwd_nil_d;
      fwd_qid_q   <= fwd_qid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      hnext_q     <= hnext_d;
      if (link_we) begin
        link_vld_q[link_wa] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      e_cmd_q <= cmd_e'(s_axis_tuser_i[0]);
      e_qid_q <= s_axis_tuser_i[3:1];
      e_val_q <= s_axis_tdata_i;
    end
    if (e_fire) begin
      r_ok_q  <= enq_ok || deq_ok;
      r_deq_q <= (e_cmd_q == CMD_DEQ);
    end
    if (r_fire) begin
      o_ok_q  <= r_ok_q;
      o_val_q <= (r_ok_q && r_deq_q) ? data_rdata_q : '0;
    end
  end

  // link store: an entry never written reads as its reset chain value
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rdata_q <= link_vld_q[link_ra] ? link_mem[link_ra] :
                    ptr_t'(link_ra) + ptr_t'(1);
  end

  // data store
  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[free_head_q[IDX_W-1:0]] <= e_val_q;
    end
    if (e_fire) begin
      data_rdata_q <= data_mem[sel_head[IDX_W-1:0]];
    end
  end

  a_deq_frees_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_fire && deq_ok |=> free_head_q == $past(sel_head))
    else $error("dequeued slot not pushed onto free list");

  a_enq_sets_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_fire && enq_ok |=> tail_q[$past(e_qid_q)] == $past(free_head_q))
    else $error("enqueued slot not linked as queue tail");

  a_head_not_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_fire && deq_ok |-> sel_head != free_head_q)
    else $error("queue head is also the free-list head");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_fire |=> r_valid_q && (r_ok_q == $past(enq_ok || deq_ok)))
    else $error("executed item did not reach the result stage");

endmodule
